FILE: rtl/weighted_thread_selector_macros.svh
// Assertion helpers for the thread selector.
`ifndef WEIGHTED_THREAD_SELECTOR_MACROS_SVH
`define WEIGHTED_THREAD_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wts_pkg.sv
package wts_pkg;

  localparam int MAX_THREADS = 7;
  localparam int NUM_ENTRIES = MAX_THREADS + 1;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_BITS    = 3;
  localparam int LVL_BITS    = 6;
  // count plus twice the index
  localparam int W_BITS      = COUNT_BITS + 1;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_RESCHED = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [IDX_BITS-1:0] thread_index;
    logic                entry_present;
    logic                entry_running;
    logic                entry_stopped;
    logic [LVL_BITS-1:0] entry_level;
    logic                clear_count;
    logic [LVL_BITS-1:0] current_level;
    logic                in_exception;
    logic                wait_flag;
  } in_item_t;

  typedef struct packed {
    logic                switched;
    logic                deferred;
    logic [IDX_BITS-1:0] chosen_thread;
    logic [IDX_BITS-1:0] active_now;
    logic [IDX_BITS-1:0] pending_now;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic write_entry;
    logic req_defer;
    logic scan_init;
    logic scan_step;
    logic sel_scan;
    logic commit_defer;
    logic do_switch;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_exc;
    logic       hold;
    logic       scan_last;
    logic       differs;
    logic       out_free;
  } dp_status_t;

endpackage

FILE: rtl/wts_datapath.sv
module wts_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wts_pkg::in_item_t  item_i,
  input  wts_pkg::ctrl_cmd_t cmd_i,
  output wts_pkg::dp_status_t status_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output wts_pkg::out_item_t out_item_o
);
  import wts_pkg::*;

  in_item_t item_q;

  logic [NUM_ENTRIES-1:0] present_q, running_q, stopped_q;
  logic [LVL_BITS-1:0]    level_q [NUM_ENTRIES];
  logic [COUNT_BITS-1:0]  count_q [NUM_ENTRIES];

  logic [IDX_BITS-1:0] active_q, pending_q, scan_q, chosen_q;
  logic                found_q;
  logic [W_BITS-1:0]   best_w_q;
  logic [LVL_BITS-1:0] best_lvl_q;
  logic                switched_q, deferred_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [IDX_BITS-1:0]   rd_idx;
  logic [LVL_BITS-1:0]   rd_lvl;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [W_BITS-1:0]     rd_w;
  logic                  eligible, take;

  // single table read port: scan pointer or switch target
  assign rd_idx = cmd_i.sel_scan ? scan_q : chosen_q;
  assign rd_lvl = level_q[rd_idx];
  assign rd_cnt = count_q[rd_idx];

  always_comb begin
    rd_w     = W_BITS'(rd_cnt) + W_BITS'({rd_idx, 1'b0});
    eligible = present_q[rd_idx] && running_q[rd_idx] && !stopped_q[rd_idx] &&
               (rd_lvl >= item_q.current_level) && (rd_lvl >= best_lvl_q);
    take     = eligible && (!found_q || (rd_w < best_w_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
  end

  // thread table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      running_q <= NUM_ENTRIES'(1);
      stopped_q <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        level_q[i] <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.write_entry) begin
      present_q[item_q.thread_index] <= item_q.entry_present;
      running_q[item_q.thread_index] <= item_q.entry_running;
      stopped_q[item_q.thread_index] <= item_q.entry_stopped;
      level_q[item_q.thread_index]   <= item_q.entry_level;
      if (item_q.clear_count) begin
        count_q[item_q.thread_index] <= '0;
      end
    end else if (cmd_i.do_switch && !stopped_q[chosen_q]) begin
      running_q[chosen_q] <= 1'b1;
      if (rd_cnt != '1) begin
        count_q[chosen_q] <= rd_cnt + COUNT_BITS'(1);
      end
    end
  end

  // scheduling state and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      pending_q  <= '0;
      scan_q     <= '0;
      chosen_q   <= '0;
      found_q    <= 1'b0;
      best_w_q   <= '0;
      best_lvl_q <= '0;
      switched_q <= 1'b0;
      deferred_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        chosen_q   <= (item_i.operation == OP_REQUEST) ? item_i.thread_index : '0;
        switched_q <= 1'b0;
        deferred_q <= 1'b0;
      end
      if (cmd_i.req_defer) begin
        if (pending_q < item_q.thread_index) begin
          pending_q <= item_q.thread_index;
        end
        deferred_q <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        scan_q     <= IDX_BITS'(1);
        chosen_q   <= '0;
        found_q    <= 1'b0;
        best_w_q   <= '0;
        best_lvl_q <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + IDX_BITS'(1);
        if (take) begin
          found_q    <= 1'b1;
          best_w_q   <= rd_w;
          best_lvl_q <= rd_lvl;
          chosen_q   <= scan_q;
        end
      end
      if (cmd_i.commit_defer) begin
        pending_q  <= chosen_q;
        deferred_q <= 1'b1;
      end
      if (cmd_i.do_switch && !stopped_q[chosen_q]) begin
        active_q   <= chosen_q;
        switched_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.switched      <= switched_q;
      out_q.deferred      <= deferred_q;
      out_q.chosen_thread <= chosen_q;
      out_q.active_now    <= active_q;
      out_q.pending_now   <= pending_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o.op        = item_q.operation;
    status_o.in_exc    = item_q.in_exception;
    status_o.hold      = (active_q == '0) && !item_q.wait_flag;
    status_o.scan_last = (scan_q == IDX_BITS'(MAX_THREADS));
    status_o.differs   = (chosen_q != active_q);
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

FILE: rtl/wts_ctrl.sv
module wts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wts_pkg::dp_status_t status_i,
  output wts_pkg::ctrl_cmd_t  cmd_o
);
  import wts_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;
  localparam logic [2:0] S_SWITCH  = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status_i.op)
          OP_WRITE: begin
            cmd_o.write_entry = 1'b1;
            state_d           = S_FINISH;
          end
          OP_RESCHED: begin
            if (status_i.hold) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          OP_REQUEST: begin
            if (status_i.in_exc) begin
              cmd_o.req_defer = 1'b1;
              state_d         = S_FINISH;
            end else begin
              state_d = S_SWITCH;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_SCAN: begin
        cmd_o.sel_scan  = 1'b1;
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!status_i.differs) begin
          state_d = S_FINISH;
        end else if (status_i.in_exc) begin
          cmd_o.commit_defer = 1'b1;
          state_d            = S_FINISH;
        end else begin
          state_d = S_SWITCH;
        end
      end
      S_SWITCH: begin
        cmd_o.do_switch = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/weighted_thread_selector.sv
// channel | direction | handshake                | payload
// in      | to block  | in_valid_i / in_stall_o  | in_item_i  (wts_pkg::in_item_t)
// out     | from block| out_valid_o / out_stall_i| out_item_o (wts_pkg::out_item_t)
//
// One item at a time. Write and unused ops and held reschedules go from execute to
// finish, a request via switch unless deferred, a scanning reschedule via scan,
// resolve and, if it switches, switch: one table entry is read per scan cycle.
// Reset clears the whole table at once (entry 0 marked running); no sweep.
// The result sits in an output register; while it is stalled the finished item
// waits in its last state and the input stays stalled until the register frees.
`include "weighted_thread_selector_macros.svh"

module weighted_thread_selector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wts_pkg::out_item_t out_item_o
);
  import wts_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // terms for the checks below
  logic in_beat;
  logic is_switch, switch_ok;
  logic is_defer, defer_ok;

  wts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // thread table, scan unit and output register
  wts_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  assign in_beat   = in_valid_i && !in_stall_o;
  assign is_switch = out_valid_o && out_item_o.switched;
  assign switch_ok = (out_item_o.active_now == out_item_o.chosen_thread) &&
                     !out_item_o.deferred;
  assign is_defer  = out_valid_o && out_item_o.deferred;
  assign defer_ok  = out_item_o.pending_now >= out_item_o.chosen_thread;

  // a beat taken leaves the input stalled in the next cycle
  `WTS_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, in_stall_o, "no busy after beat")
  // a switch leaves the chosen thread active
  `WTS_ASSERT_NOW(a_switch_active, clk_i, rst_ni, is_switch, switch_ok, "switch result wrong")
  // a deferral leaves pending at or above the chosen thread
  `WTS_ASSERT_NOW(a_defer_pending, clk_i, rst_ni, is_defer, defer_ok, "deferral lost pending")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import wts_pkg::*;

  // Unused op code: the block must leave all state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Quiet cycles (no beat on either side) before the run is called hung.
  // Worst case is an 80% idle gap followed by a switching scan and an 80%
  // stall run; those are geometric, so the limit is many times the slowest case.
  localparam int QUIET_LIMIT = 2000;
  // Settle after the last result: longer than a reschedule.
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PER_PHASE = 332;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  weighted_thread_selector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow thread table: the scheduler state as the block should hold it.
  // ---------------------------------------------------------------------
  bit [NUM_ENTRIES-1:0] tbl_present;
  bit [NUM_ENTRIES-1:0] tbl_running;
  bit [NUM_ENTRIES-1:0] tbl_stopped;
  bit [LVL_BITS-1:0]    tbl_level [NUM_ENTRIES];
  bit [COUNT_BITS-1:0]  tbl_count [NUM_ENTRIES];
  bit [IDX_BITS-1:0]    cur_active;
  bit [IDX_BITS-1:0]    cur_pending;

  out_item_t outcomes_due[$];

  int idle_pct;
  int stall_pct;
  int mismatch_count;
  int beats_sent;
  int outcomes_checked;
  int switch_total;
  int defer_total;
  int scan_total;
  int quiet_cycles;

  // Make thread t active; a stopped thread refuses. Count saturates.
  function automatic bit take_thread(bit [IDX_BITS-1:0] t);
    if (tbl_stopped[t]) return 1'b0;
    cur_active     = t;
    tbl_running[t] = 1'b1;
    if (tbl_count[t] != '1) tbl_count[t] = tbl_count[t] + 1'b1;
    return 1'b1;
  endfunction

  // Apply one beat to the shadow table and return the outcome it must give.
  function automatic out_item_t next_outcome(in_item_t b);
    out_item_t         r;
    bit                found;
    bit [W_BITS-1:0]   best_w;
    bit [W_BITS-1:0]   w;
    bit [LVL_BITS-1:0] best_lvl;
    r = '0;
    case (b.operation)
      OP_WRITE: begin
        tbl_present[b.thread_index] = b.entry_present;
        tbl_running[b.thread_index] = b.entry_running;
        tbl_stopped[b.thread_index] = b.entry_stopped;
        tbl_level[b.thread_index]   = b.entry_level;
        if (b.clear_count) tbl_count[b.thread_index] = '0;
      end
      OP_RESCHED: begin
        // Thread 0 idle and not waiting: reschedule is held off.
        if (cur_active != 0 || b.wait_flag) begin
          found    = 1'b0;
          best_w   = '0;
          best_lvl = '0;
          // Ascending scan; level may only climb, weight must strictly drop.
          for (int t = 1; t <= MAX_THREADS; t++) begin
            if (tbl_present[t] && tbl_running[t] && !tbl_stopped[t] &&
                tbl_level[t] >= b.current_level && tbl_level[t] >= best_lvl) begin
              w = W_BITS'(tbl_count[t]) + W_BITS'(2 * t);
              if (!found || w < best_w) begin
                found           = 1'b1;
                best_w          = w;
                best_lvl        = tbl_level[t];
                r.chosen_thread = IDX_BITS'(t);
              end
            end
          end
          if (r.chosen_thread != cur_active) begin
            if (!b.in_exception) begin
              r.switched = take_thread(r.chosen_thread);
            end else begin
              cur_pending = r.chosen_thread;
              r.deferred  = 1'b1;
            end
          end
        end
      end
      OP_REQUEST: begin
        r.chosen_thread = b.thread_index;
        if (!b.in_exception) begin
          r.switched = take_thread(b.thread_index);
        end else begin
          // Deferred request only ever raises the pending index.
          if (cur_pending < b.thread_index) cur_pending = b.thread_index;
          r.deferred = 1'b1;
        end
      end
      default: ;
    endcase
    r.active_now  = cur_active;
    r.pending_now = cur_pending;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input side. Valid stays high from one beat into the next unless the
  // idle draw drops it; only one NBA per falling edge.
  // ---------------------------------------------------------------------
  task automatic send_beat(input in_item_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    // accepted on this edge
    outcomes_due.push_back(next_outcome(b));
    beats_sent++;
    if (b.operation == OP_RESCHED) scan_total++;
  endtask

  // Drop valid and hold off until every outcome has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t sched_beat(logic [1:0] op, logic [IDX_BITS-1:0] idx,
                                          logic exc, logic waitf,
                                          logic [LVL_BITS-1:0] cur_lvl);
    in_item_t b;
    b               = '0;
    b.operation     = op;
    b.thread_index  = idx;
    b.in_exception  = exc;
    b.wait_flag     = waitf;
    b.current_level = cur_lvl;
    return b;
  endfunction

  function automatic in_item_t entry_beat(logic [IDX_BITS-1:0] idx, logic pres,
                                          logic run, logic stop,
                                          logic [LVL_BITS-1:0] lvl, logic clr);
    in_item_t b;
    b               = '0;
    b.operation     = OP_WRITE;
    b.thread_index  = idx;
    b.entry_present = pres;
    b.entry_running = run;
    b.entry_stopped = stop;
    b.entry_level   = lvl;
    b.clear_count   = clr;
    return b;
  endfunction

  // Mostly live threads at a few close levels so the scan has real
  // contenders and ties; occasional full-range levels and noise.
  function automatic in_item_t random_beat();
    in_item_t b;
    int       sel;
    sel             = $urandom_range(99);
    b.operation     = (sel < 28) ? OP_WRITE :
                      (sel < 62) ? OP_RESCHED :
                      (sel < 96) ? OP_REQUEST : OP_UNUSED;
    b.thread_index  = IDX_BITS'($urandom_range(MAX_THREADS));
    b.entry_present = ($urandom_range(99) < 85);
    b.entry_running = ($urandom_range(99) < 75);
    b.entry_stopped = ($urandom_range(99) < 12);
    b.entry_level   = ($urandom_range(9) == 0) ? LVL_BITS'($urandom) :
                                                 LVL_BITS'($urandom_range(3));
    b.clear_count   = ($urandom_range(99) < 15);
    b.current_level = ($urandom_range(9) == 0) ? LVL_BITS'($urandom) :
                                                 LVL_BITS'($urandom_range(2));
    b.in_exception  = ($urandom_range(99) < 30);
    b.wait_flag     = 1'($urandom_range(1));
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stall, and field-by-field check of each beat.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic void check_field(string name, logic [IDX_BITS-1:0] want,
                                      logic [IDX_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcomes_due.size() == 0) begin
        $error("result beat with nothing outstanding: %h", out_item_o);
        mismatch_count++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("switched", IDX_BITS'(want.switched), IDX_BITS'(out_item_o.switched));
        check_field("deferred", IDX_BITS'(want.deferred), IDX_BITS'(out_item_o.deferred));
        check_field("chosen_thread", want.chosen_thread, out_item_o.chosen_thread);
        check_field("active_now", want.active_now, out_item_o.active_now);
        check_field("pending_now", want.pending_now, out_item_o.pending_now);
        outcomes_checked++;
        if (want.switched) switch_total++;
        if (want.deferred) defer_total++;
      end
    end
  end

  // Hang detector: resets on any beat in either direction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("timeout: %0d quiet cycles, %0d results outstanding",
               quiet_cycles, outcomes_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Ops that must change nothing: unused code, held reschedule, empty scan.
  task automatic test_quiet_ops();
    send_beat('1);                                            // unused op, all fields high
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b0, 1'b0, 6'd0)); // thread 0, no wait: held
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b0, 1'b1, 6'd0)); // empty table: picks 0, same
  endtask

  // Scan rules: level floor, best-level floor, weight, stopped and absent.
  task automatic test_scan();
    send_beat(entry_beat(3'd7, 1'b1, 1'b1, 1'b0, 6'd63, 1'b1));
    send_beat(entry_beat(3'd3, 1'b1, 1'b1, 1'b0, 6'd0, 1'b1));
    send_beat(entry_beat(3'd5, 1'b1, 1'b1, 1'b1, 6'd63, 1'b0));  // stopped, never chosen
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b0, 1'b1, 6'd63));  // only 7 clears level 63
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b0, 1'b0, 6'd0));   // 3 lighter than 7
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b1, 1'b0, 6'd0));   // same thread: no change
    send_beat(entry_beat(3'd3, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0));   // 3 not running
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b1, 1'b0, 6'd0));   // in exception: pend 7
    send_beat(entry_beat(3'd0, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0));   // stop thread 0
    send_beat(entry_beat(3'd7, 1'b0, 1'b1, 1'b0, 6'd63, 1'b1));  // 7 absent
    send_beat(sched_beat(OP_RESCHED, 3'd0, 1'b0, 1'b1, 6'd0));   // falls to 0, refused
  endtask

  // Direct requests inside and outside an exception.
  task automatic test_requests();
    send_beat(sched_beat(OP_REQUEST, 3'd5, 1'b0, 1'b0, 6'd0));   // stopped target
    send_beat(sched_beat(OP_REQUEST, 3'd2, 1'b0, 1'b0, 6'd0));
    send_beat(sched_beat(OP_REQUEST, 3'd1, 1'b1, 1'b0, 6'd0));   // pending 7 stays
    send_beat(entry_beat(3'd0, 1'b1, 1'b1, 1'b0, 6'd0, 1'b1));   // release thread 0
    send_beat(sched_beat(OP_REQUEST, 3'd0, 1'b0, 1'b0, 6'd0));
    send_beat(sched_beat(OP_REQUEST, 3'd0, 1'b0, 1'b0, 6'd0));   // already active: still switches
    send_beat(sched_beat(OP_REQUEST, 3'd6, 1'b1, 1'b1, 6'd63));
    wait_drained();
  endtask

  // Random traffic under four idle/stall mixes, draining between mixes.
  task automatic test_random_traffic();
    int idle_mix  [4] = '{0, 80, 0, 14};
    int stall_mix [4] = '{0, 0, 80, 14};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      repeat (RANDOM_PER_PHASE) send_beat(random_beat());
      wait_drained();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    // shadow table at its reset state
    tbl_present = '0;
    tbl_running = NUM_ENTRIES'(1);
    tbl_stopped = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_level[i] = '0;
      tbl_count[i] = '0;
    end
    cur_active  = '0;
    cur_pending = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_quiet_ops();
    test_scan();
    test_requests();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d beats in (%0d reschedules), %0d results checked", beats_sent,
             scan_total, outcomes_checked);
    $display("%0d switches, %0d deferrals, %0d mismatches", switch_total,
             defer_total, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/wts_pkg.sv
rtl/wts_datapath.sv
rtl/wts_ctrl.sv
rtl/weighted_thread_selector.sv
bench/tb.sv
